@@ rtl/hsv_to_rgb_converter_assert.svh @@
// Assertion helpers for the converter's RTL; hsv2rgb_div uses them.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Implication checked on every rising edge of clk_i.
`define HSV2RGB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant checked on every rising edge of clk_i.
`define HSV2RGB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

@@ rtl/hsv2rgb_pkg.sv @@
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned COMPONENT_BITS_DEF = 8;

  // Hue is in 1/64 degree units.
  localparam int unsigned HUE_W      = 16;
  localparam int unsigned FRAC_W     = 12;
  localparam int unsigned HUE_FULL   = 23040;  // 360 degrees
  localparam int unsigned HUE_SECTOR = 3840;   // 60 degrees

  // Sector of the color wheel, named by the hue at its start.
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

endpackage

`default_nettype wire

@@ rtl/hsv2rgb_sector.sv @@
`default_nettype none

module hsv2rgb_sector #(
  parameter int unsigned COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]     hue_i,
  input  logic [COMPONENT_BITS-1:0]         sat_i,
  input  logic [COMPONENT_BITS-1:0]         val_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output hsv2rgb_pkg::sector_e              sector_o,
  output logic [hsv2rgb_pkg::FRAC_W-1:0]    frac_o,
  output logic [COMPONENT_BITS-1:0]         sat_o,
  output logic [COMPONENT_BITS-1:0]         val_o
);
  import hsv2rgb_pkg::*;

  logic                   en;
  logic                   vld_q;
  logic [HUE_W-1:0]       hue_w;
  logic [HUE_W-1:0]       base_w;
  logic [HUE_W-1:0]       rem_w;
  sector_e                sec_d, sec_q;
  logic [FRAC_W-1:0]      frac_q;
  logic [COMPONENT_BITS-1:0] sat_q, val_q;

  assign en      = !vld_q || !stall_i;
  assign stall_o = !en;

  // Wrap, then find the sector by comparing against the sector starts.
  always_comb begin
    hue_w = (hue_i >= HUE_W'(HUE_FULL)) ? '0 : hue_i;
    if (hue_w >= HUE_W'(5 * HUE_SECTOR)) begin
      sec_d  = SEC_MAGENTA;
      base_w = HUE_W'(5 * HUE_SECTOR);
    end else if (hue_w >= HUE_W'(4 * HUE_SECTOR)) begin
      sec_d  = SEC_BLUE;
      base_w = HUE_W'(4 * HUE_SECTOR);
    end else if (hue_w >= HUE_W'(3 * HUE_SECTOR)) begin
      sec_d  = SEC_CYAN;
      base_w = HUE_W'(3 * HUE_SECTOR);
    end else if (hue_w >= HUE_W'(2 * HUE_SECTOR)) begin
      sec_d  = SEC_GREEN;
      base_w = HUE_W'(2 * HUE_SECTOR);
    end else if (hue_w >= HUE_W'(HUE_SECTOR)) begin
      sec_d  = SEC_YELLOW;
      base_w = HUE_W'(HUE_SECTOR);
    end else begin
      sec_d  = SEC_RED;
      base_w = '0;
    end
    rem_w = hue_w - base_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sec_q  <= sec_d;
      frac_q <= rem_w[FRAC_W-1:0];
      sat_q  <= sat_i;
      val_q  <= val_i;
    end
  end

  assign valid_o  = vld_q;
  assign sector_o = sec_q;
  assign frac_o   = frac_q;
  assign sat_o    = sat_q;
  assign val_o    = val_q;

endmodule

`default_nettype wire

@@ rtl/hsv2rgb_mult.sv @@
`default_nettype none

module hsv2rgb_mult #(
  parameter int unsigned COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          stall_o,
  input  hsv2rgb_pkg::sector_e                          sector_i,
  input  logic [hsv2rgb_pkg::FRAC_W-1:0]                frac_i,
  input  logic [COMPONENT_BITS-1:0]                     sat_i,
  input  logic [COMPONENT_BITS-1:0]                     val_i,
  output logic                                          valid_o,
  input  logic                                          stall_i,
  output hsv2rgb_pkg::sector_e                          sector_o,
  output logic [COMPONENT_BITS-1:0]                     val_o,
  output logic [2*COMPONENT_BITS+hsv2rgb_pkg::FRAC_W-1:0] qnum_o,
  output logic [2*COMPONENT_BITS+hsv2rgb_pkg::FRAC_W-1:0] tnum_o,
  output logic [2*COMPONENT_BITS-1:0]                   pnum_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned CB    = COMPONENT_BITS;
  localparam int unsigned DEN_W = CB + FRAC_W;
  localparam int unsigned NUM_W = 2 * CB + FRAC_W;
  localparam int unsigned PN_W  = 2 * CB;
  localparam logic [CB-1:0]    M_VAL    = '1;
  localparam logic [DEN_W-1:0] DEN      = DEN_W'(HUE_SECTOR * ((2 ** CB) - 1));
  localparam logic [NUM_W-1:0] HALF_DEN = NUM_W'((HUE_SECTOR / 2) * ((2 ** CB) - 1));
  localparam logic [PN_W-1:0]  HALF_M   = PN_W'((2 ** (CB - 1)) - 1);

  logic en_a, en_b;
  logic vld_a_q, vld_b_q;

  // First stage: s*r, s*(sector - r) and the p numerator biased for rounding.
  logic [DEN_W-1:0] sr_d, src_d, sr_a_q, src_a_q;
  logic [PN_W-1:0]  pn_d, pn_a_q, pn_b_q;
  sector_e          sec_a_q, sec_b_q;
  logic [CB-1:0]    v_a_q, v_b_q;

  // Second stage: scale by v and add half the divisor for rounding.
  logic [NUM_W-1:0] qn_d, tn_d, qn_b_q, tn_b_q;

  assign en_b    = !vld_b_q || !stall_i;
  assign en_a    = !vld_a_q || en_b;
  assign stall_o = !en_a;

  assign sr_d  = DEN_W'(sat_i) * DEN_W'(frac_i);
  assign src_d = DEN_W'(sat_i) * DEN_W'(FRAC_W'(HUE_SECTOR) - frac_i);
  assign pn_d  = PN_W'(val_i) * PN_W'(M_VAL - sat_i) + HALF_M;

  assign qn_d = NUM_W'(v_a_q) * NUM_W'(DEN - sr_a_q) + HALF_DEN;
  assign tn_d = NUM_W'(v_a_q) * NUM_W'(DEN - src_a_q) + HALF_DEN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (en_a) begin
        vld_a_q <= valid_i;
      end
      if (en_b) begin
        vld_b_q <= vld_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      sr_a_q  <= sr_d;
      src_a_q <= src_d;
      pn_a_q  <= pn_d;
      sec_a_q <= sector_i;
      v_a_q   <= val_i;
    end
    if (en_b) begin
      qn_b_q  <= qn_d;
      tn_b_q  <= tn_d;
      pn_b_q  <= pn_a_q;
      sec_b_q <= sec_a_q;
      v_b_q   <= v_a_q;
    end
  end

  assign valid_o  = vld_b_q;
  assign sector_o = sec_b_q;
  assign val_o    = v_b_q;
  assign qnum_o   = qn_b_q;
  assign tnum_o   = tn_b_q;
  assign pnum_o   = pn_b_q;

endmodule

`default_nettype wire

@@ rtl/hsv2rgb_div.sv @@
`default_nettype none

`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_div #(
  parameter int unsigned COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          stall_o,
  input  hsv2rgb_pkg::sector_e                          sector_i,
  input  logic [COMPONENT_BITS-1:0]                     val_i,
  input  logic [2*COMPONENT_BITS+hsv2rgb_pkg::FRAC_W-1:0] qnum_i,
  input  logic [2*COMPONENT_BITS+hsv2rgb_pkg::FRAC_W-1:0] tnum_i,
  input  logic [2*COMPONENT_BITS-1:0]                   pnum_i,
  output logic                                          valid_o,
  input  logic                                          stall_i,
  output hsv2rgb_pkg::sector_e                          sector_o,
  output logic [COMPONENT_BITS-1:0]                     val_o,
  output logic [COMPONENT_BITS-1:0]                     q_o,
  output logic [COMPONENT_BITS-1:0]                     t_o,
  output logic [COMPONENT_BITS-1:0]                     p_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned CB     = COMPONENT_BITS;
  localparam int unsigned DEN_W  = CB + FRAC_W;
  localparam int unsigned NUM_W  = 2 * CB + FRAC_W;
  localparam int unsigned PN_W   = 2 * CB;
  localparam int unsigned EST_W  = CB + 1;
  localparam int unsigned PROD_W = 2 * EST_W;

  // Divisors: sector length times full scale for q and t, full scale for p.
  localparam longint unsigned COMP_M  = (64'd1 << CB) - 64'd1;
  localparam longint unsigned DEN_N_L = 64'(HUE_SECTOR) * COMP_M;

  // Keep the top EST_W bits of the numerator, above a shift no larger than the
  // divisor, and scale by the truncated reciprocal: the estimate is low by 0..2.
  localparam int unsigned     SH_N    = $clog2(DEN_N_L + 64'd1) - 1;
  localparam int unsigned     SH_P    = CB - 1;
  localparam longint unsigned RCP_N_L = (64'd1 << (EST_W + SH_N)) / DEN_N_L;
  localparam longint unsigned RCP_P_L = (64'd1 << (EST_W + SH_P)) / COMP_M;

  localparam logic [EST_W-1:0] RCP_N  = EST_W'(RCP_N_L);
  localparam logic [EST_W-1:0] RCP_P  = EST_W'(RCP_P_L);
  localparam logic [DEN_W-1:0] DEN_N  = DEN_W'(DEN_N_L);
  localparam logic [CB-1:0]    DEN_P  = CB'(COMP_M);
  localparam logic [NUM_W-1:0] DEN_N1 = NUM_W'(DEN_N_L);
  localparam logic [NUM_W-1:0] DEN_N2 = NUM_W'(64'd2 * DEN_N_L);
  localparam logic [NUM_W-1:0] DEN_N3 = NUM_W'(64'd3 * DEN_N_L);
  localparam logic [PN_W-1:0]  DEN_P1 = PN_W'(COMP_M);
  localparam logic [PN_W-1:0]  DEN_P2 = PN_W'(64'd2 * COMP_M);
  localparam logic [PN_W-1:0]  DEN_P3 = PN_W'(64'd3 * COMP_M);

  logic [2:0]        en;
  logic [2:0]        vld_q;

  // Estimate stage.
  logic [PROD_W-1:0] q_prod, t_prod, p_prod;
  logic [CB-1:0]     qe_a_q, te_a_q, pe_a_q;
  logic [NUM_W-1:0]  qn_a_q, tn_a_q;
  logic [PN_W-1:0]   pn_a_q;
  sector_e           sec_a_q;
  logic [CB-1:0]     v_a_q;

  // Remainder stage.
  logic [NUM_W-1:0]  qr_d, tr_d, qr_b_q, tr_b_q;
  logic [PN_W-1:0]   pr_d, pr_b_q;
  logic [CB-1:0]     qe_b_q, te_b_q, pe_b_q;
  sector_e           sec_b_q;
  logic [CB-1:0]     v_b_q;

  // Correction stage.
  logic [CB-1:0]     qc_d, tc_d, pc_d, qc_q, tc_q, pc_q;
  sector_e           sec_c_q;
  logic [CB-1:0]     v_c_q;

  logic              rem_ok, le_val_ok, p_min_ok;

  // A stage advances when it is empty or the one after it advances.
  assign en[2]   = !vld_q[2] || !stall_i;
  assign en[1]   = !vld_q[1] || en[2];
  assign en[0]   = !vld_q[0] || en[1];
  assign stall_o = !en[0];

  assign q_prod = PROD_W'(qnum_i[SH_N +: EST_W]) * PROD_W'(RCP_N);
  assign t_prod = PROD_W'(tnum_i[SH_N +: EST_W]) * PROD_W'(RCP_N);
  assign p_prod = PROD_W'(pnum_i[SH_P +: EST_W]) * PROD_W'(RCP_P);

  assign qr_d = qn_a_q - NUM_W'(qe_a_q) * NUM_W'(DEN_N);
  assign tr_d = tn_a_q - NUM_W'(te_a_q) * NUM_W'(DEN_N);
  assign pr_d = pn_a_q - PN_W'(pe_a_q) * PN_W'(DEN_P);

  // Add back what the estimate missed.
  always_comb begin
    if (qr_b_q >= DEN_N2) begin
      qc_d = qe_b_q + CB'(2);
    end else if (qr_b_q >= DEN_N1) begin
      qc_d = qe_b_q + CB'(1);
    end else begin
      qc_d = qe_b_q;
    end
    if (tr_b_q >= DEN_N2) begin
      tc_d = te_b_q + CB'(2);
    end else if (tr_b_q >= DEN_N1) begin
      tc_d = te_b_q + CB'(1);
    end else begin
      tc_d = te_b_q;
    end
    if (pr_b_q >= DEN_P2) begin
      pc_d = pe_b_q + CB'(2);
    end else if (pr_b_q >= DEN_P1) begin
      pc_d = pe_b_q + CB'(1);
    end else begin
      pc_d = pe_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= valid_i;
      end
      if (en[1]) begin
        vld_q[1] <= vld_q[0];
      end
      if (en[2]) begin
        vld_q[2] <= vld_q[1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      qe_a_q  <= q_prod[EST_W +: CB];
      te_a_q  <= t_prod[EST_W +: CB];
      pe_a_q  <= p_prod[EST_W +: CB];
      qn_a_q  <= qnum_i;
      tn_a_q  <= tnum_i;
      pn_a_q  <= pnum_i;
      sec_a_q <= sector_i;
      v_a_q   <= val_i;
    end
    if (en[1]) begin
      qr_b_q  <= qr_d;
      tr_b_q  <= tr_d;
      pr_b_q  <= pr_d;
      qe_b_q  <= qe_a_q;
      te_b_q  <= te_a_q;
      pe_b_q  <= pe_a_q;
      sec_b_q <= sec_a_q;
      v_b_q   <= v_a_q;
    end
    if (en[2]) begin
      qc_q    <= qc_d;
      tc_q    <= tc_d;
      pc_q    <= pc_d;
      sec_c_q <= sec_b_q;
      v_c_q   <= v_b_q;
    end
  end

  assign valid_o  = vld_q[2];
  assign sector_o = sec_c_q;
  assign val_o    = v_c_q;
  assign q_o      = qc_q;
  assign t_o      = tc_q;
  assign p_o      = pc_q;

  assign rem_ok    = (qr_b_q < DEN_N3) && (tr_b_q < DEN_N3) && (pr_b_q < DEN_P3);
  assign le_val_ok = (qc_q <= v_c_q) && (tc_q <= v_c_q) && (pc_q <= v_c_q);
  assign p_min_ok  = (pc_q <= qc_q) && (pc_q <= tc_q);

  `HSV2RGB_ASSERT_IMPL(a_div_rem_bound, vld_q[1], rem_ok, "quotient estimate off by more than two")
  `HSV2RGB_ASSERT_IMPL(a_div_le_val, vld_q[2], le_val_ok, "component exceeds brightness")
  `HSV2RGB_ASSERT_IMPL(a_div_p_min, vld_q[2], p_min_ok, "p is not the smallest component")
  `HSV2RGB_ASSERT_IMPL(a_div_stall_full, stall_o, &vld_q, "pipeline stalls with a free stage")

endmodule

`default_nettype wire

@@ rtl/hsv_to_rgb_converter.sv @@
// HSV to RGB pixel converter.
// Throughput: one transaction per cycle while out_stall_i is low; stages are hue
// decode, two multiply stages, three divider stages (estimate, remainder,
// correction) and the output register.
// Reset (rst_ni, async, active low) clears only the stage valid bits; payload is unreset.
`default_nettype none

module hsv_to_rgb_converter #(
  parameter int unsigned COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Pixel input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]   hue_i,
  input  logic [COMPONENT_BITS-1:0]       saturation_i,
  input  logic [COMPONENT_BITS-1:0]       brightness_i,
  // Pixel output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [COMPONENT_BITS-1:0]       red_o,
  output logic [COMPONENT_BITS-1:0]       green_o,
  output logic [COMPONENT_BITS-1:0]       blue_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned CB    = COMPONENT_BITS;
  localparam int unsigned NUM_W = 2 * CB + FRAC_W;
  localparam int unsigned PN_W  = 2 * CB;

  // Sector decode -> multiply stages.
  logic              sec_valid, sec_stall;
  sector_e           sec_sector;
  logic [FRAC_W-1:0] sec_frac;
  logic [CB-1:0]     sec_sat, sec_val;

  // Multiply stages -> divider pipeline.
  logic              mul_valid, mul_stall;
  sector_e           mul_sector;
  logic [CB-1:0]     mul_val;
  logic [NUM_W-1:0]  mul_qnum, mul_tnum;
  logic [PN_W-1:0]   mul_pnum;

  // Divider pipeline -> output register.
  logic              div_valid, div_stall;
  sector_e           div_sector;
  logic [CB-1:0]     div_val, div_q, div_t, div_p;

  // Output register.
  logic              out_en;
  logic              out_vld_q;
  logic [CB-1:0]     red_d, green_d, blue_d;
  logic [CB-1:0]     red_q, green_q, blue_q;

  // Wrap the hue and split it into sector and position within the sector.
  hsv2rgb_sector #(
    .COMPONENT_BITS(CB)
  ) u_sector (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .hue_i    (hue_i),
    .sat_i    (saturation_i),
    .val_i    (brightness_i),
    .valid_o  (sec_valid),
    .stall_i  (sec_stall),
    .sector_o (sec_sector),
    .frac_o   (sec_frac),
    .sat_o    (sec_sat),
    .val_o    (sec_val)
  );

  // Form the p, q and t numerators, already biased for round-half-up.
  hsv2rgb_mult #(
    .COMPONENT_BITS(CB)
  ) u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sec_valid),
    .stall_o  (sec_stall),
    .sector_i (sec_sector),
    .frac_i   (sec_frac),
    .sat_i    (sec_sat),
    .val_i    (sec_val),
    .valid_o  (mul_valid),
    .stall_i  (mul_stall),
    .sector_o (mul_sector),
    .val_o    (mul_val),
    .qnum_o   (mul_qnum),
    .tnum_o   (mul_tnum),
    .pnum_o   (mul_pnum)
  );

  // Divide by the constant divisors: reciprocal estimate, remainder, correction.
  hsv2rgb_div #(
    .COMPONENT_BITS(CB)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mul_valid),
    .stall_o  (mul_stall),
    .sector_i (mul_sector),
    .val_i    (mul_val),
    .qnum_i   (mul_qnum),
    .tnum_i   (mul_tnum),
    .pnum_i   (mul_pnum),
    .valid_o  (div_valid),
    .stall_i  (div_stall),
    .sector_o (div_sector),
    .val_o    (div_val),
    .q_o      (div_q),
    .t_o      (div_t),
    .p_o      (div_p)
  );

  // Route v, p, q, t to the color channels by sector.
  always_comb begin
    case (div_sector)
      SEC_RED: begin
        red_d = div_val; green_d = div_t;   blue_d = div_p;
      end
      SEC_YELLOW: begin
        red_d = div_q;   green_d = div_val; blue_d = div_p;
      end
      SEC_GREEN: begin
        red_d = div_p;   green_d = div_val; blue_d = div_t;
      end
      SEC_CYAN: begin
        red_d = div_p;   green_d = div_q;   blue_d = div_val;
      end
      SEC_BLUE: begin
        red_d = div_t;   green_d = div_p;   blue_d = div_val;
      end
      default: begin
        red_d = div_val; green_d = div_p;   blue_d = div_q;
      end
    endcase
  end

  // Hold the result while the consumer stalls; load whenever the slot frees up,
  // so the pipeline keeps accepting transactions behind a waiting result.
  assign out_en    = !out_vld_q || !out_stall_i;
  assign div_stall = !out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

`default_nettype wire

@@ tb/tb_hsv_to_rgb_converter.sv @@
module tb_hsv_to_rgb_converter;
  import hsv2rgb_pkg::*;

  localparam int unsigned CB           = COMPONENT_BITS_DEF;
  localparam int unsigned COMP_MAX     = (1 << CB) - 1;
  // Drain time: the block's latency plus a margin on top.
  localparam int unsigned DRAIN_CYCLES = 7 + 20;
  localparam int unsigned HOLD_LEN     = 80;
  localparam int unsigned CYCLE_LIMIT  = 60000;
  localparam int unsigned IDLE_PCT     = 6;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } rgb_pixel_t;

  // Every block input starts at a known value.
  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic [HUE_W-1:0]  hue_i        = '0;
  logic [CB-1:0]     saturation_i = '0;
  logic [CB-1:0]     brightness_i = '0;
  logic              out_stall_i  = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [CB-1:0]     red_o;
  logic [CB-1:0]     green_o;
  logic [CB-1:0]     blue_o;

  // Expected RGB pixels, oldest first.
  rgb_pixel_t  expected_pixels[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Idle rates of the two sides, in percent per cycle.
  int unsigned sender_idle_pct = IDLE_PCT;
  int unsigned stall_pct       = IDLE_PCT;

  // Long output hold-off: bump the request count; the receiver serves it.
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  hsv_to_rgb_converter #(
    .COMPONENT_BITS(CB)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Compute the expected RGB pixel in exact integer arithmetic. Each of p, q and
  // t is a scaled product rounded to nearest with ties going up.
  function automatic rgb_pixel_t hsv_to_rgb_expected(input logic [HUE_W-1:0] hue,
                                                     input logic [CB-1:0] sat,
                                                     input logic [CB-1:0] bri);
    longint unsigned h;
    longint unsigned rem;
    longint unsigned den;
    longint unsigned s;
    longint unsigned v;
    longint unsigned p;
    longint unsigned q;
    longint unsigned t;
    sector_e         wheel;
    rgb_pixel_t      px;
    h = hue;
    s = sat;
    v = bri;
    // Fold a hue at or past a full turn back to red.
    if (h >= HUE_FULL) begin
      h = 0;
    end
    wheel = sector_e'(h / HUE_SECTOR);
    rem   = h % HUE_SECTOR;
    den   = HUE_SECTOR * COMP_MAX;
    p = (v * (COMP_MAX - s) + COMP_MAX / 2) / COMP_MAX;
    q = (v * (den - s * rem) + den / 2) / den;
    t = (v * (den - s * (HUE_SECTOR - rem)) + den / 2) / den;
    case (wheel)
      SEC_RED: begin
        px.red = v[CB-1:0]; px.green = t[CB-1:0]; px.blue = p[CB-1:0];
      end
      SEC_YELLOW: begin
        px.red = q[CB-1:0]; px.green = v[CB-1:0]; px.blue = p[CB-1:0];
      end
      SEC_GREEN: begin
        px.red = p[CB-1:0]; px.green = v[CB-1:0]; px.blue = t[CB-1:0];
      end
      SEC_CYAN: begin
        px.red = p[CB-1:0]; px.green = q[CB-1:0]; px.blue = v[CB-1:0];
      end
      SEC_BLUE: begin
        px.red = t[CB-1:0]; px.green = p[CB-1:0]; px.blue = v[CB-1:0];
      end
      default: begin
        px.red = v[CB-1:0]; px.green = p[CB-1:0]; px.blue = q[CB-1:0];
      end
    endcase
    return px;
  endfunction

  // Offer one pixel and hold it until the block takes it. Idle cycles go in
  // before the offer, never while a pixel is waiting.
  task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [CB-1:0] sat,
                            input logic [CB-1:0] bri);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    hue_i        <= hue;
    saturation_i <= sat;
    brightness_i <= bri;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  // Draw one pixel with its weight on the interesting corners: sector edges,
  // the wrap region above a full turn, and full or zero saturation and value.
  task automatic send_random_pixel();
    int unsigned       pick;
    logic [HUE_W-1:0]  hue;
    logic [CB-1:0]     sat;
    logic [CB-1:0]     bri;
    pick = $urandom_range(99);
    if (pick < 75) begin
      hue = HUE_W'($urandom_range(HUE_FULL - 1));
    end else if (pick < 88) begin
      hue = HUE_W'($urandom_range((1 << HUE_W) - 1, HUE_FULL));
    end else begin
      // Land just on either side of a sector boundary.
      hue = HUE_W'($urandom_range(5) * HUE_SECTOR + $urandom_range(1));
      if ($urandom_range(1) == 1 && hue != 0) begin
        hue = hue - HUE_W'($urandom_range(1, 2));
      end
    end
    pick = $urandom_range(99);
    sat = (pick < 8) ? '0 : (pick < 16) ? CB'(COMP_MAX) : CB'($urandom());
    pick = $urandom_range(99);
    bri = (pick < 8) ? '0 : (pick < 16) ? CB'(COMP_MAX) : CB'($urandom());
    send_pixel(hue, sat, bri);
  endtask

  // Hit the start and the last step of every sector at strong saturation.
  task automatic test_sector_edges();
    for (int k = 0; k < 6; k++) begin
      send_pixel(HUE_W'(k * HUE_SECTOR), CB'(COMP_MAX), CB'(COMP_MAX));
      send_pixel(HUE_W'(k * HUE_SECTOR + HUE_SECTOR - 1), CB'(200), CB'(COMP_MAX));
    end
  endtask

  // Check the last hue below a full turn, a full turn, and the largest hue.
  task automatic test_hue_wrap();
    send_pixel(HUE_W'(HUE_FULL - 1), CB'(COMP_MAX), CB'(COMP_MAX));
    send_pixel(HUE_W'(HUE_FULL), CB'(COMP_MAX), CB'(COMP_MAX));
    send_pixel('1, CB'(COMP_MAX), CB'(COMP_MAX));
  endtask

  // Cover gray at zero saturation, black at zero value, and small operands.
  task automatic test_gray_and_dark();
    send_pixel(HUE_W'(12345), '0, CB'(200));
    send_pixel('0, '0, CB'(COMP_MAX));
    send_pixel(HUE_W'(7000), CB'(COMP_MAX), '0);
    send_pixel(HUE_W'(9000), CB'(COMP_MAX), CB'(1));
    send_pixel(HUE_W'(HUE_SECTOR / 2), CB'(1), CB'(COMP_MAX));
    send_pixel(HUE_W'(HUE_SECTOR / 2), CB'(128), CB'(128));
  endtask

  // Stream pixels with no idling on either side.
  task automatic test_back_to_back(input int unsigned count);
    sender_idle_pct = 0;
    stall_pct      <= 0;
    repeat (count) send_random_pixel();
    sender_idle_pct = IDLE_PCT;
    stall_pct      <= IDLE_PCT;
  endtask

  // Hold the output off long enough that the pipeline fills and the input
  // stalls, while pixels keep being offered.
  task automatic test_output_hold(input int unsigned count);
    hold_requests <= hold_requests + 1;
    repeat (count) send_random_pixel();
  endtask

  // Run random pixels with the default idle rates on both sides.
  task automatic test_random(input int unsigned count);
    repeat (count) send_random_pixel();
  endtask

  // Receiver: serve a pending hold-off first, then stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_LEN - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Scoreboard: queue the expected pixel for each accepted input transaction,
  // then compare each accepted output transaction against the oldest entry.
  // Inputs are handled first so a same-edge pair stays in order.
  always @(posedge clk_i) begin
    rgb_pixel_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_pixels.push_back(hsv_to_rgb_expected(hue_i, saturation_i, brightness_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected output pixel r=%0d g=%0d b=%0d", red_o, green_o, blue_o);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (red_o !== want.red) begin
            $error("red expected %0d actual %0d", want.red, red_o);
            mismatch_count++;
          end
          if (green_o !== want.green) begin
            $error("green expected %0d actual %0d", want.green, green_o);
            mismatch_count++;
          end
          if (blue_o !== want.blue) begin
            $error("blue expected %0d actual %0d", want.blue, blue_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // Hold reset at the start, then release it once.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sector_edges();
    test_hue_wrap();
    test_gray_and_dark();
    test_back_to_back(200);
    test_output_hold(50);
    test_random(1180);

    // Drop valid, drain the pipeline, then give any stray output time to show.
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
